[rtl/core/assert_macros.svh]
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside of reset.
`define CHK_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define CHK_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/bpit_pkg.sv]
`default_nettype none

package bpit_pkg;

  localparam int PACKET_LENGTH  = 32;
  localparam int BUFFER_PACKETS = 4;
  localparam int CAPACITY       = PACKET_LENGTH * BUFFER_PACKETS;

  localparam int SLOT_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int FILL_W = 8;
  localparam int CNT_W  = $clog2(PACKET_LENGTH + 1);
  localparam int TMO_W  = 16;

  localparam logic [TMO_W-1:0]  TIMEOUT_RESET = TMO_W'(100);
  localparam logic [FILL_W-1:0] FILL_CAP      = FILL_W'(CAPACITY);
  localparam logic [FILL_W-1:0] FILL_PKT      = FILL_W'(PACKET_LENGTH);
  localparam logic [SLOT_W-1:0] SLOT_LAST     = SLOT_W'(CAPACITY - 1);
  localparam logic [CNT_W-1:0]  PKT_CNT       = CNT_W'(PACKET_LENGTH);

  localparam logic [1:0] ACT_BYTE = 2'd0;
  localparam logic [1:0] ACT_TICK = 2'd1;
  localparam logic [1:0] ACT_READ = 2'd2;

  typedef enum logic [2:0] {
    ST_ACCEPTED  = 3'd0,
    ST_DROPPED   = 3'd1,
    ST_NO_FLUSH  = 3'd2,
    ST_FLUSHED   = 3'd3,
    ST_PKT_BYTE  = 3'd4,
    ST_NOT_READY = 3'd5
  } status_t;

  typedef struct packed {
    logic byte_wr;
    logic tick;
    logic not_ready;
    logic mem_rd;
    logic pkt_load;
    logic pkt_last;
  } cmd_t;

endpackage

`default_nettype wire

[rtl/core/bpit_dp.sv]
`default_nettype none

module bpit_dp (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire bpit_pkg::cmd_t                cmd,
  input  wire logic [7:0]                    rx_byte,
  input  wire logic                          cfg_we,
  input  wire logic [bpit_pkg::TMO_W-1:0]    cfg_wdata,
  output logic                               fill_ge_pkt,
  output bpit_pkg::status_t                  out_status,
  output logic [7:0]                         out_byte,
  output logic                               out_last,
  output logic                               out_pkt_ready,
  output logic [bpit_pkg::FILL_W-1:0]        out_held
);

  logic [7:0]                   mem [bpit_pkg::CAPACITY];
  logic [7:0]                   rdata;
  logic [bpit_pkg::SLOT_W-1:0]  write_slot, write_slot_next;
  logic [bpit_pkg::SLOT_W-1:0]  read_slot;
  logic [bpit_pkg::FILL_W-1:0]  fill_level, fill_level_next;
  logic [bpit_pkg::TMO_W-1:0]   idle_count, idle_count_next;
  logic [bpit_pkg::TMO_W-1:0]   timeout_ticks;
  logic [bpit_pkg::TMO_W-1:0]   idle_inc;
  logic                         full, flush, do_write, load;
  bpit_pkg::status_t            status_next;

  function automatic logic [bpit_pkg::SLOT_W-1:0] slot_inc(
    input logic [bpit_pkg::SLOT_W-1:0] s
  );
    return (s == bpit_pkg::SLOT_LAST) ? '0 : s + 1'b1;
  endfunction

  assign full        = (fill_level >= bpit_pkg::FILL_CAP);
  assign fill_ge_pkt = (fill_level >= bpit_pkg::FILL_PKT);
  assign idle_inc    = (idle_count == '1) ? idle_count : idle_count + 1'b1;
  assign flush       = (fill_level != '0) && (idle_inc > timeout_ticks);
  assign do_write    = cmd.byte_wr && !full;
  assign load        = cmd.byte_wr || cmd.tick || cmd.not_ready || cmd.pkt_load;

  always_comb begin
    write_slot_next = write_slot;
    fill_level_next = fill_level;
    idle_count_next = idle_count;
    status_next     = bpit_pkg::ST_NOT_READY;
    if (cmd.byte_wr) begin
      if (full) begin
        status_next = bpit_pkg::ST_DROPPED;
      end else begin
        status_next     = bpit_pkg::ST_ACCEPTED;
        write_slot_next = slot_inc(write_slot);
        fill_level_next = fill_level + 1'b1;
        idle_count_next = '0;
      end
    end else if (cmd.tick) begin
      if (flush) begin
        status_next     = bpit_pkg::ST_FLUSHED;
        write_slot_next = '0;
        fill_level_next = '0;
        idle_count_next = '0;
      end else begin
        status_next     = bpit_pkg::ST_NO_FLUSH;
        idle_count_next = idle_inc;
      end
    end else if (cmd.pkt_load) begin
      status_next     = bpit_pkg::ST_PKT_BYTE;
      fill_level_next = fill_level - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_write) begin
      mem[write_slot] <= rx_byte;
    end
    if (cmd.mem_rd) begin
      rdata <= mem[read_slot];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot    <= '0;
      read_slot     <= '0;
      fill_level    <= '0;
      idle_count    <= '0;
      timeout_ticks <= bpit_pkg::TIMEOUT_RESET;
    end else begin
      write_slot <= write_slot_next;
      fill_level <= fill_level_next;
      idle_count <= idle_count_next;
      if (cmd.tick && flush) begin
        read_slot <= '0;
      end else if (cmd.mem_rd) begin
        read_slot <= slot_inc(read_slot);
      end
      if (cfg_we) begin
        timeout_ticks <= cfg_wdata;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (load) begin
      out_status    <= status_next;
      out_byte      <= cmd.pkt_load ? rdata : 8'd0;
      out_last      <= cmd.pkt_load ? cmd.pkt_last : 1'b1;
      out_pkt_ready <= (fill_level_next >= bpit_pkg::FILL_PKT);
      out_held      <= fill_level_next;
    end
  end

endmodule

`default_nettype wire

[rtl/core/bpit_ctrl.sv]
`default_nettype none

module bpit_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  input  wire logic [1:0]      in_action,
  output logic                 in_ready,
  output logic                 out_valid,
  input  wire logic            out_ready,
  input  wire logic            fill_ge_pkt,
  output bpit_pkg::cmd_t       cmd,
  output logic                 busy
);

  typedef enum logic [1:0] {
    S_IDLE   = 2'b01,
    S_STREAM = 2'b10
  } state_t;

  state_t                      state, state_next;
  logic [bpit_pkg::CNT_W-1:0]  issue_left, issue_left_next;
  logic [bpit_pkg::CNT_W-1:0]  load_left, load_left_next;
  logic                        pending, pending_next;
  logic                        out_valid_next;
  logic                        out_free, accept, any_load;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE) && out_free;
  assign accept   = in_valid && in_ready;
  assign busy     = (state == S_STREAM);
  assign any_load = cmd.byte_wr || cmd.tick || cmd.not_ready || cmd.pkt_load;

  always_comb begin
    state_next      = state;
    issue_left_next = issue_left;
    load_left_next  = load_left;
    pending_next    = pending;
    cmd             = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          priority case (in_action)
            bpit_pkg::ACT_BYTE: cmd.byte_wr = 1'b1;
            bpit_pkg::ACT_TICK: cmd.tick    = 1'b1;
            bpit_pkg::ACT_READ: begin
              if (fill_ge_pkt) begin
                state_next      = S_STREAM;
                issue_left_next = bpit_pkg::PKT_CNT;
                load_left_next  = bpit_pkg::PKT_CNT;
                pending_next    = 1'b0;
              end else begin
                cmd.not_ready = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      S_STREAM: begin
        cmd.pkt_load = pending && out_free;
        cmd.pkt_last = (load_left == bpit_pkg::CNT_W'(1));
        cmd.mem_rd   = (issue_left != '0) && (!pending || cmd.pkt_load);
        if (cmd.mem_rd) begin
          issue_left_next = issue_left - 1'b1;
          pending_next    = 1'b1;
        end else if (cmd.pkt_load) begin
          pending_next = 1'b0;
        end
        if (cmd.pkt_load) begin
          load_left_next = load_left - 1'b1;
          if (cmd.pkt_last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign out_valid_next = any_load ? 1'b1 : (out_ready ? 1'b0 : out_valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      issue_left <= '0;
      load_left  <= '0;
      pending    <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      issue_left <= issue_left_next;
      load_left  <= load_left_next;
      pending    <= pending_next;
      out_valid  <= out_valid_next;
    end
  end

endmodule

`default_nettype wire

[rtl/core/byte_packetizer_idle_timeout.sv]
// Byte packetizer with idle timeout.
// Slave stream: tuser carries the action (received byte, time tick, read
// one packet), tdata the received byte. Master stream: one transaction per
// result; tuser is the status, tlast marks the final result of an input,
// tdata carries the packet byte, the packet-ready flag and the held count.
// cfg_we/cfg_wdata write the idle timeout in ticks (reset value 100);
// write it only while the block is idle.
// A byte or tick gives one result, registered in the cycle after acceptance.
// A read with a full packet held streams PACKET_LENGTH bytes: the first
// passes the state, byte-store read and result registers, then one per
// cycle follows while the receiver takes them, paced by the single read
// port of the byte store; a read with less held gives one not-ready result.
// Input is accepted one transaction per cycle whenever the result register
// is empty or being drained; s_axis_tready stays low while a packet streams.
// If the receiver stalls, the result register holds and input backs up.
// Reset (synchronous) empties the buffer, clears the idle count and
// restores the timeout; the byte store itself is not cleared.
`default_nettype none

`include "assert_macros.svh"

module byte_packetizer_idle_timeout (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  wire logic [1:0]  s_axis_tuser,   // [1:0] action
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,   // [7:0] out_byte, [8] packet_ready,
                                           // [16:9] held_count, [23:17] zero
  output logic [2:0]       m_axis_tuser,   // [2:0] status
  output logic             m_axis_tlast,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata
);

  bpit_pkg::cmd_t                 cmd;
  bpit_pkg::status_t              out_status;
  logic [7:0]                     out_byte;
  logic                           out_pkt_ready;
  logic [bpit_pkg::FILL_W-1:0]    out_held;
  logic                           fill_ge_pkt;
  logic                           busy;

  bpit_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_axis_tvalid),
    .in_action   (s_axis_tuser),
    .in_ready    (s_axis_tready),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .fill_ge_pkt (fill_ge_pkt),
    .cmd         (cmd),
    .busy        (busy)
  );

  bpit_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .rx_byte       (s_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .fill_ge_pkt   (fill_ge_pkt),
    .out_status    (out_status),
    .out_byte      (out_byte),
    .out_last      (m_axis_tlast),
    .out_pkt_ready (out_pkt_ready),
    .out_held      (out_held)
  );

  assign m_axis_tuser = out_status;
  assign m_axis_tdata = {7'd0, out_held, out_pkt_ready, out_byte};

  `CHK_ASSERT(a_no_input_while_streaming, clk, rst, busy |-> !s_axis_tready, "input taken during packet")
  `CHK_ASSERT(a_single_op, clk, rst, $onehot0({cmd.byte_wr, cmd.tick, cmd.not_ready, cmd.pkt_load}), "overlapping operations")
  `CHK_ASSERT(a_held_in_range, clk, rst, m_axis_tvalid |-> (out_held <= bpit_pkg::FILL_CAP), "held count beyond capacity")
  `CHK_ASSERT(a_last_ends_stream, clk, rst, (cmd.pkt_load && cmd.pkt_last) |=> !busy, "stream continues after last byte")

endmodule

`default_nettype wire

[tb/testbench.sv]
`default_nettype none

module testbench;
  import bpit_pkg::*;

  localparam logic [1:0] ACT_NONE = 2'd3;  // unused action code, ignored by the block
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct packed {
    status_t            status;
    logic [7:0]         data;
    logic               last;
    logic               ready;
    logic [FILL_W-1:0]  held;
  } pkt_result_t;

  class packet_fifo_model;
    logic [7:0]        byte_store [CAPACITY];
    logic [SLOT_W-1:0] wr_slot;
    logic [SLOT_W-1:0] rd_slot;
    logic [FILL_W-1:0] fill;
    logic [TMO_W-1:0]  idle;
    logic [TMO_W-1:0]  timeout;
    pkt_result_t       pending_results[$];
    int                errors;

    function new();
      wr_slot = '0;
      rd_slot = '0;
      fill    = '0;
      idle    = '0;
      timeout = TIMEOUT_RESET;
      errors  = 0;
    endfunction

    function logic [SLOT_W-1:0] next_slot(logic [SLOT_W-1:0] s);
      return (s == SLOT_LAST) ? '0 : s + 1'b1;
    endfunction

    function void push_result(status_t st, logic [7:0] data, logic last);
      pkt_result_t r;
      r.status = st;
      r.data   = data;
      r.last   = last;
      r.ready  = (fill >= FILL_PKT);
      r.held   = fill;
      pending_results.push_back(r);
    endfunction

    function void note_input(logic [1:0] action, logic [7:0] rx);
      logic [7:0] d;
      case (action)
        ACT_BYTE: begin
          if (fill >= FILL_CAP) begin
            push_result(ST_DROPPED, 8'd0, 1'b1);
          end else begin
            byte_store[wr_slot] = rx;
            wr_slot = next_slot(wr_slot);
            fill = fill + 1'b1;
            idle = '0;
            push_result(ST_ACCEPTED, 8'd0, 1'b1);
          end
        end
        ACT_TICK: begin
          if (idle != '1) idle = idle + 1'b1;
          if (fill != 0 && idle > timeout) begin
            wr_slot = '0;
            rd_slot = '0;
            fill    = '0;
            idle    = '0;
            push_result(ST_FLUSHED, 8'd0, 1'b1);
          end else begin
            push_result(ST_NO_FLUSH, 8'd0, 1'b1);
          end
        end
        ACT_READ: begin
          if (fill < FILL_PKT) begin
            push_result(ST_NOT_READY, 8'd0, 1'b1);
          end else begin
            for (int i = 0; i < PACKET_LENGTH; i++) begin
              d = byte_store[rd_slot];
              rd_slot = next_slot(rd_slot);
              fill = fill - 1'b1;
              push_result(ST_PKT_BYTE, d, i == PACKET_LENGTH - 1);
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void flag(string what, logic [15:0] want, logic [15:0] got);
      errors++;
      if (errors <= 10) $display("Mismatch in %s: expected %0d, got %0d", what, want, got);
    endfunction

    function void check_result(logic [2:0] st, logic [7:0] data, logic last, logic ready,
                               logic [FILL_W-1:0] held);
      pkt_result_t want;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("Result with no transaction pending: status %0d", st);
        return;
      end
      want = pending_results.pop_front();
      if (want.status !== st)    flag("status", 16'(want.status), 16'(st));
      if (want.data !== data)    flag("out_byte", 16'(want.data), 16'(data));
      if (want.last !== last)    flag("last", 16'(want.last), 16'(last));
      if (want.ready !== ready)  flag("packet_ready", 16'(want.ready), 16'(ready));
      if (want.held !== held)    flag("held_count", 16'(want.held), 16'(held));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'd0;
  logic [1:0]  s_axis_tuser = ACT_BYTE;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = 16'd0;

  logic gaps_on   = 1'b1;
  logic stalls_on = 1'b1;
  logic hold_off  = 1'b0;
  int   cycle_count = 0;

  packet_fifo_model fifo_model = new();

  byte_packetizer_idle_timeout uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      fifo_model.check_result(m_axis_tuser, m_axis_tdata[7:0], m_axis_tlast,
                              m_axis_tdata[8], m_axis_tdata[16:9]);
    end
  end

  // receiver: random stall bursts, plus one long hold-off on request
  initial begin
    int hold_cnt;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        m_axis_tready = 1'b0;
        for (hold_cnt = 0; hold_cnt < HOLD_CYCLES; hold_cnt++) @(negedge clk);
        hold_off = 1'b0;
        m_axis_tready = 1'b1;
      end else if (!rst && stalls_on && $urandom_range(0, 9) == 0) begin
        m_axis_tready = 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
        m_axis_tready = 1'b1;
      end else begin
        m_axis_tready = 1'b1;
      end
    end
  end

  // called at a falling edge; returns at a falling edge
  task automatic send_item(input logic [1:0] action, input logic [7:0] rx);
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = action;
    s_axis_tdata  = rx;
    do @(posedge clk); while (!s_axis_tready);
    fifo_model.note_input(action, rx);
    @(negedge clk);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    s_axis_tvalid = 1'b0;
    while (fifo_model.pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_timeout(input logic [15:0] ticks);
    wait_drained();
    cfg_wdata = ticks;
    cfg_we    = 1'b1;
    @(negedge clk);
    cfg_we    = 1'b0;
    fifo_model.timeout = ticks;
  endtask

  // mostly byte runs and reads so packets build up; ticks, noise and pauses mixed in
  task automatic random_traffic(input int target);
    int sent;
    int pick;
    int n;
    sent = 0;
    while (sent < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        n = $urandom_range(1, 40);
        if (n > target - sent) n = target - sent;
        repeat (n) send_item(ACT_BYTE, 8'($urandom_range(0, 255)));
        sent += n;
      end else if (pick < 65) begin
        send_item(ACT_READ, 8'($urandom_range(0, 255)));
        sent++;
      end else if (pick < 80) begin
        n = $urandom_range(1, 8);
        if (n > target - sent) n = target - sent;
        repeat (n) send_item(ACT_TICK, 8'($urandom_range(0, 255)));
        sent += n;
      end else if (pick < 92) begin
        send_item(2'($urandom_range(0, 2)), 8'($urandom_range(0, 255)));
        sent++;
      end else if (pick < 96) begin
        send_item(ACT_NONE, 8'($urandom_range(0, 255)));
        sent++;
      end else begin
        wait_drained();
      end
    end
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst = 1'b0;

    // directed
    set_timeout(16'd3);
    send_item(ACT_READ, 8'hFF);
    send_item(ACT_TICK, 8'h00);
    send_item(ACT_NONE, 8'h55);
    send_item(ACT_BYTE, 8'h00);
    send_item(ACT_BYTE, 8'hFF);
    send_item(ACT_BYTE, 8'h5A);
    repeat (4) send_item(ACT_TICK, 8'hA5);
    send_item(ACT_READ, 8'h00);
    send_item(ACT_BYTE, 8'hA5);
    send_item(ACT_READ, 8'h00);

    // receiver holds off, the buffer is overfilled, then packets drain
    wait_drained();
    hold_off = 1'b1;
    repeat (CAPACITY + 2) send_item(ACT_BYTE, 8'($urandom_range(0, 255)));
    repeat (BUFFER_PACKETS + 1) send_item(ACT_READ, 8'($urandom_range(0, 255)));

    set_timeout(16'd0);
    random_traffic(6);
    set_timeout(16'($urandom_range(4, 20)));
    random_traffic(6);

    // last part: no idling; short timeout so held bytes get flushed
    set_timeout(16'd2);
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    repeat (4) send_item(ACT_BYTE, 8'($urandom_range(0, 255)));
    repeat (3) send_item(ACT_TICK, 8'($urandom_range(0, 255)));
    send_item(ACT_READ, 8'h00);

    s_axis_tvalid = 1'b0;
    while (fifo_model.pending_results.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fifo_model.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire

[byte_packetizer_idle_timeout.f]
+incdir+rtl/core
rtl/core/bpit_pkg.sv
rtl/core/bpit_dp.sv
rtl/core/bpit_ctrl.sv
rtl/core/byte_packetizer_idle_timeout.sv
tb/testbench.sv
